FILE: hdl/cle_pkg.sv
`default_nettype none

package cle_pkg;

  localparam int CLE_CAPACITY   = 64;
  localparam int CLE_DATA_WIDTH = 32;

  typedef enum logic [3:0] {
    OP_START       = 4'd0,
    OP_END         = 4'd1,
    OP_ADVANCE     = 4'd2,
    OP_RETREAT     = 4'd3,
    OP_INSERT      = 4'd4,
    OP_INSERT_FRNT = 4'd5,
    OP_ATTACH      = 4'd6,
    OP_ATTACH_BACK = 4'd7,
    OP_REMOVE_CUR  = 4'd8,
    OP_REMOVE_FRNT = 4'd9,
    OP_READ_AT     = 4'd10
  } cle_op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_ITEM = 2'd2
  } cle_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_GATHER,
    S_REDUCE
  } cle_state_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] value;
    logic [5:0]  position;
  } cle_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [6:0]  entry_count;
    logic [6:0]  cursor_pos;
    logic        has_current;
  } cle_out_t;

  typedef struct packed {
    logic ins;
    logic rem;
    logic gather;
    logic rd_en;
  } cle_cell_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/cle_cell.sv
`default_nettype none

module cle_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 6
) (
  input  wire                          clk,
  input  wire cle_pkg::cle_cell_ctl_t  ctl,
  input  wire  [IW-1:0]                cell_idx,
  input  wire  [IW-1:0]                at_idx,
  input  wire  [IW-1:0]                rd_idx,
  input  wire  [DATA_WIDTH-1:0]        word,
  input  wire  [DATA_WIDTH-1:0]        prev_data,
  input  wire  [DATA_WIDTH-1:0]        next_data,
  output logic [DATA_WIDTH-1:0]        data,
  output logic [DATA_WIDTH-1:0]        masked
);
  import cle_pkg::*;

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic [DATA_WIDTH-1:0] masked_r, masked_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (cell_idx > at_idx) begin
        data_nxt = prev_data;
      end else if (cell_idx == at_idx) begin
        data_nxt = word;
      end
    end else if (ctl.rem) begin
      if (cell_idx >= at_idx) begin
        data_nxt = next_data;
      end
    end
  end

  always_comb begin
    masked_nxt = masked_r;
    if (ctl.gather) begin
      masked_nxt = (ctl.rd_en && (cell_idx == rd_idx)) ? data_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    data_r   <= data_nxt;
    masked_r <= masked_nxt;
  end

  assign data   = data_r;
  assign masked = masked_r;

endmodule

`default_nettype wire

FILE: hdl/cle_ctrl.sv
`default_nettype none

module cle_ctrl #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 6,
  parameter int CW         = 7
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire cle_pkg::cle_in_t        in_item,
  output logic                         busy,
  output cle_pkg::cle_cell_ctl_t       cell_ctl,
  output logic [IW-1:0]                at_idx,
  output logic [IW-1:0]                rd_idx,
  output logic [DATA_WIDTH-1:0]        word,
  output logic [CW-1:0]                count,
  output logic [CW-1:0]                cursor,
  output logic [1:0]                   status,
  output logic                         fin
);
  import cle_pkg::*;

  localparam int MW = (CW > 6) ? CW : 6;

  cle_state_t  state_r, state_nxt;
  cle_in_t     cmd_r, cmd_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  cle_status_t status_r, status_nxt;
  logic        read_idx_r, read_idx_nxt;
  logic        rd_ok_r, rd_ok_nxt;

  cle_op_t     op;
  logic        cur;
  logic        full;
  logic        accept;
  logic [CW-1:0] at_full;
  logic        do_ins;
  logic        do_rem;
  logic        cur_after;

  assign op        = cle_op_t'(cmd_r.op);
  assign cur       = cursor_r < count_r;
  assign full      = count_r == CW'(CAPACITY);
  assign cur_after = cursor_r < count_r;
  assign busy      = (state_r == S_EXEC) || (state_r == S_GATHER);
  assign accept    = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    if (accept) begin
      cmd_nxt = in_item;
    end
    unique case (state_r)
      S_IDLE:   state_nxt = start ? S_EXEC : S_IDLE;
      S_EXEC:   state_nxt = S_GATHER;
      S_GATHER: state_nxt = S_REDUCE;
      S_REDUCE: state_nxt = start ? S_EXEC : S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt    = count_r;
    cursor_nxt   = cursor_r;
    status_nxt   = status_r;
    read_idx_nxt = read_idx_r;
    rd_ok_nxt    = rd_ok_r;
    at_full      = '0;
    do_ins       = 1'b0;
    do_rem       = 1'b0;
    if (state_r == S_EXEC) begin
      status_nxt   = ST_OK;
      read_idx_nxt = 1'b0;
      rd_ok_nxt    = 1'b0;
      if ((op == OP_INSERT || op == OP_INSERT_FRNT || op == OP_ATTACH ||
           op == OP_ATTACH_BACK) && full) begin
        status_nxt = ST_FULL;
      end else begin
        unique case (op)
          OP_START: cursor_nxt = '0;
          OP_END:   cursor_nxt = (count_r != '0) ? count_r - CW'(1) : '0;
          OP_ADVANCE: begin
            if (cur) cursor_nxt = cursor_r + CW'(1);
          end
          OP_RETREAT: begin
            if (cursor_r != '0) cursor_nxt = cursor_r - CW'(1);
          end
          OP_INSERT: begin
            at_full    = cur ? cursor_r : '0;
            do_ins     = 1'b1;
            count_nxt  = count_r + CW'(1);
            cursor_nxt = at_full;
          end
          OP_INSERT_FRNT: begin
            at_full    = '0;
            do_ins     = 1'b1;
            count_nxt  = count_r + CW'(1);
            cursor_nxt = '0;
          end
          OP_ATTACH: begin
            at_full    = cur ? cursor_r + CW'(1) : count_r;
            do_ins     = 1'b1;
            count_nxt  = count_r + CW'(1);
            cursor_nxt = at_full;
          end
          OP_ATTACH_BACK: begin
            at_full   = count_r;
            do_ins    = 1'b1;
            count_nxt = count_r + CW'(1);
          end
          OP_REMOVE_CUR: begin
            if (cur) begin
              at_full   = cursor_r;
              do_rem    = 1'b1;
              count_nxt = count_r - CW'(1);
            end else begin
              status_nxt = ST_NO_ITEM;
            end
          end
          OP_REMOVE_FRNT: begin
            if (count_r != '0) begin
              at_full   = '0;
              do_rem    = 1'b1;
              count_nxt = count_r - CW'(1);
              if (cursor_r > count_r - CW'(1)) cursor_nxt = count_r - CW'(1);
            end else begin
              status_nxt = ST_NO_ITEM;
            end
          end
          OP_READ_AT: begin
            read_idx_nxt = 1'b1;
            if (MW'(cmd_r.position) < MW'(count_r)) begin
              rd_ok_nxt = 1'b1;
            end else begin
              status_nxt = ST_NO_ITEM;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      cursor_r <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
    end
    cmd_r      <= cmd_nxt;
    status_r   <= status_nxt;
    read_idx_r <= read_idx_nxt;
    rd_ok_r    <= rd_ok_nxt;
  end

  always_comb begin
    cell_ctl.ins    = do_ins;
    cell_ctl.rem    = do_rem;
    cell_ctl.gather = state_r == S_GATHER;
    cell_ctl.rd_en  = read_idx_r ? rd_ok_r : cur_after;
  end

  assign at_idx = at_full[IW-1:0];
  assign rd_idx = read_idx_r ? IW'(cmd_r.position) : cursor_r[IW-1:0];
  assign word   = DATA_WIDTH'(cmd_r.value);
  assign count  = count_r;
  assign cursor = cursor_r;
  assign status = status_r;
  assign fin    = state_r == S_REDUCE;

endmodule

`default_nettype wire

FILE: hdl/cursor_list_engine.sv
// sequence: an accepted item passes through the execute, gather and reduce states; the result
// strobe is registered from the reduce state; busy is high in the execute and gather states
// overlap: a new item can be accepted in the reduce state, before the last result is presented;
// the execute, gather and reduce steps are taken in turn by the cell row and the read-out or tree
// reset: synchronous active-low rst_n clears count, cursor, control state and the strobe
// entries are undefined until written; results cannot be stalled by the receiver
`default_nettype none

module cursor_list_engine #(
  parameter int CAPACITY   = cle_pkg::CLE_CAPACITY,
  parameter int DATA_WIDTH = cle_pkg::CLE_DATA_WIDTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire cle_pkg::cle_in_t in_item,
  output logic                out_valid,
  output cle_pkg::cle_out_t   out_item
);
  import cle_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  cle_cell_ctl_t         cell_ctl;
  logic [IW-1:0]         at_idx;
  logic [IW-1:0]         rd_idx;
  logic [DATA_WIDTH-1:0] word;
  logic [CW-1:0]         count;
  logic [CW-1:0]         cursor;
  logic [1:0]            status;
  logic                  fin;

  logic [DATA_WIDTH-1:0] cell_data   [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_masked [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_or;

  logic     out_valid_r, out_valid_nxt;
  cle_out_t out_item_r, out_item_nxt;

  cle_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .IW         (IW),
    .CW         (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .cell_ctl (cell_ctl),
    .at_idx   (at_idx),
    .rd_idx   (rd_idx),
    .word     (word),
    .count    (count),
    .cursor   (cursor),
    .status   (status),
    .fin      (fin)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_d;
    logic [DATA_WIDTH-1:0] next_d;

    if (i == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_mid
      assign prev_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_inner
      assign next_d = cell_data[i+1];
    end

    cle_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IW         (IW)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .cell_idx  (IW'(i)),
      .at_idx    (at_idx),
      .rd_idx    (rd_idx),
      .word      (word),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i]),
      .masked    (cell_masked[i])
    );
  end

  // at most one cell holds a nonzero masked word
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_masked[i];
    end
  end

  always_comb begin
    out_valid_nxt = fin;
    out_item_nxt  = out_item_r;
    if (fin) begin
      out_item_nxt.status      = status;
      out_item_nxt.read_value  = 32'(rd_or);
      out_item_nxt.entry_count = 7'(count);
      out_item_nxt.cursor_pos  = 7'(cursor);
      out_item_nxt.has_current = cursor < count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

FILE: hdl/cle_checker.sv
`default_nettype none

module cle_checker #(
  parameter int CAPACITY = cle_pkg::CLE_CAPACITY
) (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    start,
  input wire                    busy,
  input wire                    out_valid,
  input wire cle_pkg::cle_out_t out_item
);
  import cle_pkg::*;

  localparam bit SMALL = CAPACITY < 128;

  logic accept;
  assign accept = start && !busy;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after an accepted item");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("result strobe missing after an accepted item");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe high for more than one cycle");

  a_has_current: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && SMALL) |->
      (out_item.has_current == (out_item.cursor_pos < out_item.entry_count)))
    else $error("has_current disagrees with cursor and count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && SMALL && (out_item.status == ST_FULL)) |->
      (out_item.entry_count == 7'(CAPACITY)))
    else $error("store full reported below capacity");

endmodule

bind cursor_list_engine cle_checker #(.CAPACITY(CAPACITY)) u_cle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire

FILE: tb/cursor_list_engine_tb.sv
`timescale 1ns / 100ps

module cursor_list_engine_tb;
  import cle_pkg::*;

  localparam int IDLE_LIMIT = 500;
  localparam logic [3:0] OP_UNUSED_LO = 4'd11;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  class list_mirror;
    logic [31:0] words [CLE_CAPACITY];
    int unsigned num;
    int unsigned cur_idx;
    cle_out_t    expected_replies [$];
    int unsigned mismatches;
    int unsigned commands;
    int unsigned replies;
    int unsigned full_hits;
    int unsigned no_item_hits;
    int unsigned peak;

    function void open_gap(int unsigned at);
      for (int unsigned i = num; i > at; i--) words[i] = words[i - 1];
    endfunction

    function void close_gap(int unsigned at);
      for (int unsigned i = at; i + 1 < num; i++) words[i] = words[i + 1];
    endfunction

    function void note_command(cle_in_t it);
      cle_out_t    want;
      bit          had;
      bit          by_index;
      int unsigned at;
      want = '0;
      want.status = ST_OK;
      had = cur_idx < num;
      by_index = 1'b0;
      commands++;
      if (it.op >= OP_INSERT && it.op <= OP_ATTACH_BACK && num >= CLE_CAPACITY) begin
        want.status = ST_FULL;
      end else begin
        case (it.op)
          OP_START: cur_idx = 0;
          OP_END: cur_idx = (num > 0) ? num - 1 : 0;
          OP_ADVANCE: if (cur_idx < num) cur_idx++;
          OP_RETREAT: if (cur_idx > 0) cur_idx--;
          OP_INSERT: begin
            at = had ? cur_idx : 0;
            open_gap(at);
            words[at] = it.value;
            num++;
            cur_idx = at;
          end
          OP_INSERT_FRNT: begin
            open_gap(0);
            words[0] = it.value;
            num++;
            cur_idx = 0;
          end
          OP_ATTACH: begin
            at = had ? cur_idx + 1 : num;
            open_gap(at);
            words[at] = it.value;
            num++;
            cur_idx = at;
          end
          OP_ATTACH_BACK: begin
            words[num] = it.value;
            num++;
          end
          OP_REMOVE_CUR: begin
            if (had) begin
              close_gap(cur_idx);
              num--;
            end else begin
              want.status = ST_NO_ITEM;
            end
          end
          OP_REMOVE_FRNT: begin
            if (num > 0) begin
              close_gap(0);
              num--;
              if (cur_idx > num) cur_idx = num;
            end else begin
              want.status = ST_NO_ITEM;
            end
          end
          OP_READ_AT: begin
            by_index = 1'b1;
            if (it.position < num) want.read_value = words[it.position];
            else want.status = ST_NO_ITEM;
          end
          default: ;
        endcase
      end
      want.has_current = cur_idx < num;
      if (!by_index && want.has_current) want.read_value = words[cur_idx];
      want.entry_count = 7'(num);
      want.cursor_pos = 7'(cur_idx);
      if (want.status == ST_FULL) full_hits++;
      if (want.status == ST_NO_ITEM) no_item_hits++;
      if (num > peak) peak = num;
      expected_replies.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(cle_out_t got);
      cle_out_t want;
      if (expected_replies.size() == 0) begin
        $error("result %h with no command outstanding", got);
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      replies++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      compare_field("cursor_pos", 32'(want.cursor_pos), 32'(got.cursor_pos));
      compare_field("has_current", 32'(want.has_current), 32'(got.has_current));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  cle_in_t    in_item = '0;
  logic       busy;
  logic       out_valid;
  cle_out_t   out_item;

  list_mirror  mirror = new;
  int unsigned quiet_cycles = 0;

  cursor_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) mirror.check_reply(out_item);
      if (start && busy === 1'b0) mirror.note_command(in_item);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && busy === 1'b0) || out_valid === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic issue(logic [3:0] op, logic [31:0] value, logic [5:0] position);
    cle_in_t it;
    it.op = op;
    it.value = value;
    it.position = position;
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic pause(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (mirror.expected_replies.size() != 0) @(posedge clk);
  endtask

  function automatic cle_in_t random_command(int unsigned fill, bit grow);
    cle_in_t     it;
    int unsigned pick;
    int unsigned grow_w;
    grow_w = grow ? 48 : 14;
    pick = $urandom_range(99);
    if (pick < 3) it.op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    else if (pick < 23) it.op = 4'($urandom_range(OP_RETREAT, OP_START));
    else if (pick < 23 + grow_w) it.op = 4'($urandom_range(OP_ATTACH_BACK, OP_INSERT));
    else if (pick < 85) it.op = 4'($urandom_range(OP_REMOVE_FRNT, OP_REMOVE_CUR));
    else it.op = OP_READ_AT;
    case ($urandom_range(9))
      0: it.value = '0;
      1: it.value = '1;
      default: it.value = $urandom;
    endcase
    if (fill > 0 && $urandom_range(3) != 0) it.position = 6'($urandom_range(fill - 1));
    else it.position = 6'($urandom_range(63));
    return it;
  endfunction

  task automatic run_random(int unsigned items, bit with_gaps);
    bit      grow;
    bit      calm;
    cle_in_t it;
    grow = 1'b1;
    calm = 1'b0;
    repeat (items) begin
      if (mirror.num >= CLE_CAPACITY) grow = 1'b0;
      else if (mirror.num == 0) grow = 1'b1;
      if ($urandom_range(31) == 0) calm = !calm;
      it = random_command(mirror.num, grow);
      issue(it.op, it.value, it.position);
      if (with_gaps && !calm && $urandom_range(3) == 0) pause($urandom_range(4, 1));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list
    issue(OP_REMOVE_CUR, 32'h0, 6'd0);
    issue(OP_REMOVE_FRNT, 32'h0, 6'd0);
    issue(OP_READ_AT, 32'h0, 6'd0);
    issue(OP_END, 32'h0, 6'd0);
    issue(OP_ADVANCE, 32'h0, 6'd0);
    issue(OP_RETREAT, 32'h0, 6'd0);
    issue(OP_INSERT, 32'h0000_0000, 6'd0);
    issue(OP_ATTACH, 32'hFFFF_FFFF, 6'd0);
    issue(OP_INSERT_FRNT, 32'hA5A5_5A5A, 6'd0);
    issue(OP_ATTACH_BACK, 32'h1234_5678, 6'd0);
    // cursor past the end, then insert and attach with no current item
    issue(OP_END, 32'h0, 6'd0);
    issue(OP_ADVANCE, 32'h0, 6'd0);
    issue(OP_ADVANCE, 32'h0, 6'd0);
    issue(OP_INSERT, 32'h0F0F_0F0F, 6'd0);
    issue(OP_END, 32'h0, 6'd0);
    issue(OP_ADVANCE, 32'h0, 6'd0);
    issue(OP_ATTACH, 32'hF0F0_F0F0, 6'd0);
    issue(OP_READ_AT, 32'h0, 6'd5);
    issue(OP_READ_AT, 32'h0, 6'd63);
    issue(OP_RETREAT, 32'h0, 6'd0);
    issue(OP_REMOVE_CUR, 32'h0, 6'd0);
    issue(OP_START, 32'h0, 6'd0);
    issue(OP_REMOVE_FRNT, 32'h0, 6'd0);
    issue(OP_UNUSED_HI, 32'hFFFF_FFFF, 6'd63);
    issue(OP_UNUSED_LO, 32'h0, 6'd0);
    settle();

    // fill the store, then hit the full case with every insert flavor
    repeat (CLE_CAPACITY - mirror.num) issue(OP_ATTACH_BACK, $urandom, 6'($urandom));
    issue(OP_INSERT, 32'hDEAD_BEEF, 6'd0);
    issue(OP_INSERT_FRNT, 32'hDEAD_BEEF, 6'd0);
    issue(OP_ATTACH, 32'hDEAD_BEEF, 6'd0);
    issue(OP_ATTACH_BACK, 32'hDEAD_BEEF, 6'd0);
    issue(OP_READ_AT, 32'h0, 6'd63);
    issue(OP_END, 32'h0, 6'd0);
    issue(OP_ADVANCE, 32'h0, 6'd0);
    issue(OP_REMOVE_FRNT, 32'h0, 6'd0);
    issue(OP_REMOVE_CUR, 32'h0, 6'd0);
    issue(OP_RETREAT, 32'h0, 6'd0);
    issue(OP_REMOVE_CUR, 32'h0, 6'd0);
    settle();

    run_random(450, 1'b1);
    settle();
    run_random(450, 1'b1);
    settle();
    run_random(450, 1'b0);
    settle();
    pause(8);

    $display("%0d commands driven, %0d results compared, list fill peaked at %0d of %0d",
             mirror.commands, mirror.replies, mirror.peak, CLE_CAPACITY);
    $display("store-full answers: %0d, no-item answers: %0d",
             mirror.full_hits, mirror.no_item_hits);
    if (mirror.mismatches == 0 && mirror.expected_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
